// ===== src/buzzer_beep_pattern_generator_defines.svh =====
// Assertion macros for the buzzer beep pattern generator.
`ifndef BUZZER_BEEP_PATTERN_GENERATOR_DEFINES_SVH
`define BUZZER_BEEP_PATTERN_GENERATOR_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BBPG_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bbpg_pkg.sv =====
// Shared types and constants for the buzzer beep pattern generator.
package bbpg_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [7:0] FOREVER_COUNT = 8'hff;

    typedef struct packed {
        logic       command;
        logic [7:0] repeat_count;
        logic [7:0] on_ticks;
        logic [7:0] off_ticks;
    } item_t;

    typedef struct packed {
        logic buzzer_on;
        logic pattern_active;
    } result_t;

endpackage

// ===== src/bbpg_core.sv =====
// Beep pattern state and its single-pass update for one item.
module bbpg_core
    import bbpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [3:0] {
        PH_LOAD_ON  = 4'b0001,
        PH_ON       = 4'b0010,
        PH_LOAD_OFF = 4'b0100,
        PH_OFF      = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] repeats_left_reg, repeats_left_next;
    logic [7:0] on_reload_reg, on_reload_next;
    logic [7:0] off_reload_reg, off_reload_next;
    logic [7:0] on_remaining_reg, on_remaining_next;
    logic [7:0] off_remaining_reg, off_remaining_next;
    logic       drive_level_reg, drive_level_next;

    logic [7:0] on_dec;
    logic [7:0] off_dec;

    assign on_dec  = on_remaining_reg - 8'd1;
    assign off_dec = off_remaining_reg - 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        repeats_left_next  = repeats_left_reg;
        on_reload_next     = on_reload_reg;
        off_reload_next    = off_reload_reg;
        on_remaining_next  = on_remaining_reg;
        off_remaining_next = off_remaining_reg;
        drive_level_next   = drive_level_reg;
        if (item.command)
        begin
            repeats_left_next = item.repeat_count;
            on_reload_next    = item.on_ticks;
            off_reload_next   = item.off_ticks;
            phase_next        = PH_LOAD_ON;
        end
        else if (repeats_left_reg == 8'd0)
        begin
            phase_next       = PH_LOAD_ON;
            drive_level_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_LOAD_ON:
                begin
                    on_remaining_next = on_reload_reg;
                    phase_next        = PH_ON;
                end
                PH_ON:
                begin
                    drive_level_next  = 1'b1;
                    on_remaining_next = on_dec;
                    if (on_dec == 8'd0)
                    begin
                        phase_next = PH_LOAD_OFF;
                    end
                end
                PH_LOAD_OFF:
                begin
                    off_remaining_next = off_reload_reg;
                    phase_next         = PH_OFF;
                end
                PH_OFF:
                begin
                    drive_level_next   = 1'b0;
                    off_remaining_next = off_dec;
                    if (off_dec == 8'd0)
                    begin
                        if (repeats_left_reg != FOREVER_COUNT)
                        begin
                            repeats_left_next = repeats_left_reg - 8'd1;
                        end
                        phase_next = PH_LOAD_ON;
                    end
                end
                default:
                begin
                    phase_next = PH_LOAD_ON;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LOAD_ON;
            repeats_left_reg  <= 8'd0;
            on_reload_reg     <= 8'd0;
            off_reload_reg    <= 8'd0;
            on_remaining_reg  <= 8'd0;
            off_remaining_reg <= 8'd0;
            drive_level_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            repeats_left_reg  <= repeats_left_next;
            on_reload_reg     <= on_reload_next;
            off_reload_reg    <= off_reload_next;
            on_remaining_reg  <= on_remaining_next;
            off_remaining_reg <= off_remaining_next;
            drive_level_reg   <= drive_level_next;
        end
    end

    // result seen after the update
    assign result.buzzer_on      = drive_level_next;
    assign result.pattern_active = (repeats_left_next != 8'd0);

endmodule

// ===== src/buzzer_beep_pattern_generator.sv =====
// Top level of the buzzer beep pattern generator: input and result registers.
// An input transfer is held in the input register, and its result in the result register.
// Throughput: one item per cycle while the master side takes results; the pattern state
// updates in a single pass between the input register and the result register.
// Reset: rst_n asynchronous, active low; pattern state cleared, buzzer off,
// both stream stages empty.
`include "buzzer_beep_pattern_generator_defines.svh"
module buzzer_beep_pattern_generator
    import bbpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // repeat_count, on_ticks, off_ticks
    input  logic                  s_axis_tuser,  // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // buzzer_on, pattern_active, zero pad
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t core_result;
    logic    in_xfer;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.command      <= s_axis_tuser;
            in_item_reg.repeat_count <= s_axis_tdata[7:0];
            in_item_reg.on_ticks     <= s_axis_tdata[15:8];
            in_item_reg.off_ticks    <= s_axis_tdata[23:16];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    bbpg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_result_reg.pattern_active,
                            out_result_reg.buzzer_on};

    `BBPG_ASSERT(a_full_blocks_input, !(in_valid_reg && !advance && s_axis_tready), "input taken while stage held")
    `BBPG_ASSERT_NEXT(a_advance_fills_out, advance, m_axis_tvalid, "result missing after advance")
    `BBPG_ASSERT_NEXT(a_xfer_fills_in, in_xfer, in_valid_reg, "input stage empty after transfer")

endmodule
